/* rtl/core/sh3_pkg.sv */
// Shared types and constants of the 3x3 sharpen stream filter.
// Depends on nothing; every other file of the block but sh3_fifo refers to it by scoped names.

package sh3_pkg;

	localparam int PIX_W     = 8;
	localparam int CFG_W     = 11;
	localparam int CMD_DEPTH = 4;
	localparam int RES_DEPTH = 4;

	localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_SATURATE_MODE = 2'd2;

	localparam logic [CFG_W-1:0] RESET_WIDTH  = 11'd640;
	localparam logic [CFG_W-1:0] RESET_HEIGHT = 11'd480;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_FLUSH = 1'b1
	} op_t;

	typedef logic [1:0] slot_t;

	localparam slot_t SLOT_0 = 2'd0;
	localparam slot_t SLOT_1 = 2'd1;
	localparam slot_t SLOT_2 = 2'd2;

	typedef struct packed {
		op_t              op;
		logic [PIX_W-1:0] pixel_in;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             end_of_frame;
	} out_item_t;

	typedef struct packed {
		logic  wr_en;
		slot_t wr_slot;
		logic  emit;
		logic  bypass;
		logic  left_from_c;
		slot_t slot_top;
		slot_t slot_mid;
		slot_t slot_bot;
		logic  eof;
		logic  sat;
	} ctrl_t;

endpackage

/* rtl/core/sh3_fifo.sv */
// Small synchronous queue used for the command and result requests.
// Depends on nothing outside this file.

module sh3_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty,
	output logic             full,
	output logic [CNT_W-1:0] count
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign count   = count_q;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10: begin
					count_q <= count_q + CNT_W'(1);
				end
				2'b01: begin
					count_q <= count_q - CNT_W'(1);
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

endmodule

/* rtl/core/sh3_front.sv */
// Front end: configuration registers, input and output raster counters, and the
// building of one command per request that writes a pixel or emits a result. Uses sh3_pkg.

module sh3_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	localparam int CW   = $clog2(MAX_WIDTH),
	localparam int RW   = $clog2(MAX_HEIGHT),
	localparam int FW_W = $clog2(MAX_WIDTH + 1),
	localparam int FH_W = $clog2(MAX_HEIGHT + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [1:0]                     cfg_index,
	input  logic [sh3_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           push,
	input  sh3_pkg::in_item_t              item,
	input  logic                           cmd_full,
	output logic                           cmd_push,
	output sh3_pkg::ctrl_t                 cmd_ctrl,
	output logic [CW-1:0]                  cmd_wr_col,
	output logic [CW-1:0]                  cmd_col_c,
	output logic [CW-1:0]                  cmd_col_p,
	output logic [sh3_pkg::PIX_W-1:0]      cmd_pixel
);

	function automatic sh3_pkg::slot_t slot_next(sh3_pkg::slot_t s);
		sh3_pkg::slot_t r;
		unique case (s)
			sh3_pkg::SLOT_0: r = sh3_pkg::SLOT_1;
			sh3_pkg::SLOT_1: r = sh3_pkg::SLOT_2;
			default:         r = sh3_pkg::SLOT_0;
		endcase
		return r;
	endfunction

	function automatic sh3_pkg::slot_t slot_prev(sh3_pkg::slot_t s);
		sh3_pkg::slot_t r;
		unique case (s)
			sh3_pkg::SLOT_1: r = sh3_pkg::SLOT_0;
			sh3_pkg::SLOT_2: r = sh3_pkg::SLOT_1;
			default:         r = sh3_pkg::SLOT_2;
		endcase
		return r;
	endfunction

	logic [sh3_pkg::CFG_W-1:0] width_q;
	logic [sh3_pkg::CFG_W-1:0] height_q;
	logic                      sat_q;
	logic [FW_W-1:0]           frame_w_q;
	logic [FH_W-1:0]           frame_h_q;
	logic [CW-1:0]             in_col_q;
	logic [RW-1:0]             in_row_q;
	sh3_pkg::slot_t            in_slot_q;
	logic [CW-1:0]             out_col_q;
	logic [RW-1:0]             out_row_q;
	sh3_pkg::slot_t            out_slot_q;
	logic                      in_done_q;

	logic [FW_W-1:0] fw_cfg;
	logic [FH_W-1:0] fh_cfg;
	logic [FW_W-1:0] fw_eff;
	logic [FH_W-1:0] fh_eff;
	logic            first;
	logic            in_last_col;
	logic            in_last_row;
	logic            out_last_col;
	logic            out_last_row;
	logic            pixel_step;
	logic            emit_cond;
	logic            emit;
	logic            eof;
	logic            accept;

	always_comb begin
		if (width_q == '0) begin
			fw_cfg = FW_W'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			fw_cfg = FW_W'(MAX_WIDTH);
		end else begin
			fw_cfg = FW_W'(width_q);
		end
		if (height_q == '0) begin
			fh_cfg = FH_W'(1);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			fh_cfg = FH_W'(MAX_HEIGHT);
		end else begin
			fh_cfg = FH_W'(height_q);
		end
	end

	assign first        = (in_row_q == '0) && (in_col_q == '0);
	assign fw_eff       = first ? fw_cfg : frame_w_q;
	assign fh_eff       = first ? fh_cfg : frame_h_q;
	assign in_last_col  = (FW_W'(in_col_q) + FW_W'(1)) >= fw_eff;
	assign in_last_row  = (FH_W'(in_row_q) + FH_W'(1)) >= fh_eff;
	assign out_last_col = (FW_W'(out_col_q) + FW_W'(1)) >= frame_w_q;
	assign out_last_row = (FH_W'(out_row_q) + FH_W'(1)) >= frame_h_q;
	assign eof          = out_last_row && out_last_col;

	assign pixel_step = (item.op == sh3_pkg::OP_PIXEL) && !in_done_q;
	assign emit_cond  = (in_row_q >= RW'(2)) || ((in_row_q == RW'(1)) && (in_col_q != '0));
	assign emit       = in_done_q || (pixel_step && emit_cond);
	assign accept     = push && !cmd_full;
	assign cmd_push   = accept && (pixel_step || emit);

	always_comb begin
		cmd_ctrl.wr_en       = pixel_step;
		cmd_ctrl.wr_slot     = in_slot_q;
		cmd_ctrl.emit        = emit;
		cmd_ctrl.bypass      = pixel_step && emit_cond && (in_col_q != '0);
		cmd_ctrl.left_from_c = (out_col_q == '0);
		cmd_ctrl.slot_top    = (out_row_q == '0) ? out_slot_q : slot_prev(out_slot_q);
		cmd_ctrl.slot_mid    = out_slot_q;
		cmd_ctrl.slot_bot    = out_last_row ? out_slot_q : slot_next(out_slot_q);
		cmd_ctrl.eof         = eof;
		cmd_ctrl.sat         = sat_q;
		cmd_wr_col           = in_col_q;
		cmd_col_c            = out_col_q;
		cmd_col_p            = out_last_col ? out_col_q : out_col_q + CW'(1);
		cmd_pixel            = item.pixel_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= sh3_pkg::RESET_WIDTH;
			height_q   <= sh3_pkg::RESET_HEIGHT;
			sat_q      <= 1'b0;
			frame_w_q  <= FW_W'(1);
			frame_h_q  <= FH_W'(1);
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= sh3_pkg::SLOT_0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= sh3_pkg::SLOT_0;
			in_done_q  <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					sh3_pkg::REG_IMAGE_WIDTH: begin
						width_q <= cfg_data;
					end
					sh3_pkg::REG_IMAGE_HEIGHT: begin
						height_q <= cfg_data;
					end
					sh3_pkg::REG_SATURATE_MODE: begin
						sat_q <= cfg_data[0];
					end
					default: begin
						sat_q <= sat_q;
					end
				endcase
			end
			if (accept) begin
				if (pixel_step) begin
					if (first) begin
						frame_w_q <= fw_cfg;
						frame_h_q <= fh_cfg;
					end
					if (in_last_col) begin
						in_col_q <= '0;
						if (in_last_row) begin
							in_row_q  <= '0;
							in_slot_q <= sh3_pkg::SLOT_0;
							in_done_q <= 1'b1;
						end else begin
							in_row_q  <= in_row_q + RW'(1);
							in_slot_q <= slot_next(in_slot_q);
						end
					end else begin
						in_col_q <= in_col_q + CW'(1);
					end
				end
				if (emit) begin
					if (eof) begin
						in_col_q   <= '0;
						in_row_q   <= '0;
						in_slot_q  <= sh3_pkg::SLOT_0;
						out_col_q  <= '0;
						out_row_q  <= '0;
						out_slot_q <= sh3_pkg::SLOT_0;
						in_done_q  <= 1'b0;
					end else if (out_last_col) begin
						out_col_q  <= '0;
						out_row_q  <= out_row_q + RW'(1);
						out_slot_q <= slot_next(out_slot_q);
					end else begin
						out_col_q <= out_col_q + CW'(1);
					end
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	// The last result of a frame can only come from a drain request, never alongside a pixel.
	a_eof_only_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		accept && pixel_step && emit |-> !eof)
		else $error("end of frame emitted while pixels were still arriving");

	a_done_counters_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_done_q |-> (in_col_q == '0) && (in_row_q == '0))
		else $error("input counters moved after the frame was received");
`endif

endmodule

/* rtl/core/sh3_back.sv */
// Back end: three row memories, the 3x3 window with border replication, the
// kernel arithmetic over two stages and credit control towards the result queue. Uses sh3_pkg.

module sh3_back #(
	parameter int MAX_WIDTH = 1024,
	localparam int CW    = $clog2(MAX_WIDTH),
	localparam int RCW   = $clog2(sh3_pkg::RES_DEPTH + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	input  sh3_pkg::ctrl_t            cmd_ctrl,
	input  logic [CW-1:0]             cmd_wr_col,
	input  logic [CW-1:0]             cmd_col_c,
	input  logic [CW-1:0]             cmd_col_p,
	input  logic [sh3_pkg::PIX_W-1:0] cmd_pixel,
	output logic                      cmd_pop,
	input  logic [RCW-1:0]            res_count,
	output logic                      res_push,
	output sh3_pkg::out_item_t        res_item
);

	logic [7:0] row0_mem_q [MAX_WIDTH];
	logic [7:0] row1_mem_q [MAX_WIDTH];
	logic [7:0] row2_mem_q [MAX_WIDTH];

	logic [7:0]      rd_c0_s1, rd_c1_s1, rd_c2_s1;
	logic [7:0]      rd_p0_s1, rd_p1_s1, rd_p2_s1;
	sh3_pkg::ctrl_t  ctrl_s1;
	logic [7:0]      pixel_s1;
	logic            v_s1;
	logic [2:0][7:0] left_q;

	logic [11:0] center9_s2;
	logic [10:0] nsum_s2;
	logic        eof_s2;
	logic        sat_s2;
	logic        v_s2;

	logic [1:0]       inflight;
	logic             credit_ok;
	logic             issue;
	logic [2:0][7:0]  col_l, col_m, col_r;
	logic [7:0]       tl, tc, tr, ml, mc, mr, bl, bc, br;
	logic [10:0]      nsum;
	logic [11:0]      center9;
	logic signed [12:0] diff;
	logic [7:0]       value;

	assign inflight  = {1'b0, v_s1 && ctrl_s1.emit} + {1'b0, v_s2};
	assign credit_ok = ((RCW + 2)'(res_count) + (RCW + 2)'(inflight))
		< (RCW + 2)'(sh3_pkg::RES_DEPTH);
	assign issue     = cmd_valid && (!cmd_ctrl.emit || credit_ok);
	assign cmd_pop   = issue;

	always_ff @(posedge clk) begin
		if (issue) begin
			if (cmd_ctrl.wr_en && (cmd_ctrl.wr_slot == sh3_pkg::SLOT_0)) begin
				row0_mem_q[cmd_wr_col] <= cmd_pixel;
			end
			rd_c0_s1 <= row0_mem_q[cmd_col_c];
			rd_p0_s1 <= row0_mem_q[cmd_col_p];
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			if (cmd_ctrl.wr_en && (cmd_ctrl.wr_slot == sh3_pkg::SLOT_1)) begin
				row1_mem_q[cmd_wr_col] <= cmd_pixel;
			end
			rd_c1_s1 <= row1_mem_q[cmd_col_c];
			rd_p1_s1 <= row1_mem_q[cmd_col_p];
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			if (cmd_ctrl.wr_en && (cmd_ctrl.wr_slot == sh3_pkg::SLOT_2)) begin
				row2_mem_q[cmd_wr_col] <= cmd_pixel;
			end
			rd_c2_s1 <= row2_mem_q[cmd_col_c];
			rd_p2_s1 <= row2_mem_q[cmd_col_p];
		end
	end

	// The pixel arriving with this request is not yet in memory, so it replaces the
	// bottom right corner of the window directly.
	always_comb begin
		col_m   = {rd_c2_s1, rd_c1_s1, rd_c0_s1};
		col_r   = {rd_p2_s1, rd_p1_s1, rd_p0_s1};
		col_l   = ctrl_s1.left_from_c ? col_m : left_q;
		tl      = col_l[ctrl_s1.slot_top];
		tc      = col_m[ctrl_s1.slot_top];
		tr      = col_r[ctrl_s1.slot_top];
		ml      = col_l[ctrl_s1.slot_mid];
		mc      = col_m[ctrl_s1.slot_mid];
		mr      = col_r[ctrl_s1.slot_mid];
		bl      = col_l[ctrl_s1.slot_bot];
		bc      = col_m[ctrl_s1.slot_bot];
		br      = ctrl_s1.bypass ? pixel_s1 : col_r[ctrl_s1.slot_bot];
		nsum    = 11'(tl) + 11'(tc) + 11'(tr) + 11'(ml) + 11'(mr)
			+ 11'(bl) + 11'(bc) + 11'(br);
		center9 = {1'b0, mc, 3'b000} + 12'(mc);
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			ctrl_s1  <= cmd_ctrl;
			pixel_s1 <= cmd_pixel;
		end
		if (v_s1 && ctrl_s1.emit) begin
			left_q     <= col_m;
			center9_s2 <= center9;
			nsum_s2    <= nsum;
			eof_s2     <= ctrl_s1.eof;
			sat_s2     <= ctrl_s1.sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1 && ctrl_s1.emit;
		end
	end

	always_comb begin
		diff = $signed({1'b0, center9_s2}) - $signed({2'b00, nsum_s2});
		if (!sat_s2) begin
			value = diff[7:0];
		end else if (diff < 0) begin
			value = 8'd0;
		end else if (diff > 13'sd255) begin
			value = 8'd255;
		end else begin
			value = diff[7:0];
		end
	end

	assign res_push              = v_s2;
	assign res_item.pixel_out    = value;
	assign res_item.end_of_frame = eof_s2;

`ifndef NO_ASSERTIONS
	a_result_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> res_count < RCW'(sh3_pkg::RES_DEPTH))
		else $error("result written into a full result queue");

	a_bypass_same_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		issue && cmd_ctrl.bypass |->
			cmd_ctrl.wr_en && cmd_ctrl.emit && (cmd_col_p == cmd_wr_col))
		else $error("window corner taken from a pixel other than the one being written");
`endif

endmodule

/* rtl/core/sharpen_3x3_stream.sv */
// Top level of the streaming 3x3 sharpen filter: front end, command queue, back end
// and result queue. Uses sh3_pkg, sh3_front, sh3_fifo and sh3_back.
//
//   channel   direction  handshake             payload
//   item      in         push / full           sh3_pkg::in_item_t
//   result    out        pop / empty           sh3_pkg::out_item_t
//   config    in         cfg_write, cfg_index  cfg_data
//
// One request is accepted per cycle while full is low; a result is written into the result
// queue once its command has left the command queue and passed through the registered row
// memory read and then the arithmetic register.
// The row memories need no clearing after reset.
// When pop stays low, the result queue credit holds commands back and the command
// queue then raises full.

module sharpen_3x3_stream #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [1:0]                cfg_index,
	input  logic [sh3_pkg::CFG_W-1:0] cfg_data,
	input  logic                      push,
	output logic                      full,
	input  sh3_pkg::in_item_t         item,
	output logic                      empty,
	input  logic                      pop,
	output sh3_pkg::out_item_t        result
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int CMD_W = $bits(sh3_pkg::ctrl_t) + 3 * CW + sh3_pkg::PIX_W;
	localparam int RES_W = $bits(sh3_pkg::out_item_t);
	localparam int RCW   = $clog2(sh3_pkg::RES_DEPTH + 1);

	sh3_pkg::ctrl_t            f_ctrl;
	logic [CW-1:0]             f_wr_col;
	logic [CW-1:0]             f_col_c;
	logic [CW-1:0]             f_col_p;
	logic [sh3_pkg::PIX_W-1:0] f_pixel;
	logic                      f_push;
	logic                      cmd_full;
	logic                      cmd_empty;
	logic [CMD_W-1:0]          cmd_wdata;
	logic [CMD_W-1:0]          cmd_rdata;

	sh3_pkg::ctrl_t            b_ctrl;
	logic [CW-1:0]             b_wr_col;
	logic [CW-1:0]             b_col_c;
	logic [CW-1:0]             b_col_p;
	logic [sh3_pkg::PIX_W-1:0] b_pixel;
	logic                      b_pop;

	logic                      res_push;
	sh3_pkg::out_item_t        res_item;
	logic [RES_W-1:0]          res_wdata;
	logic [RES_W-1:0]          res_rdata;
	logic [RCW-1:0]            res_count;

	assign full      = cmd_full;
	assign cmd_wdata = {f_ctrl, f_wr_col, f_col_c, f_col_p, f_pixel};
	assign {b_ctrl, b_wr_col, b_col_c, b_col_p, b_pixel} = cmd_rdata;
	assign res_wdata = res_item;
	assign result    = res_rdata;

	sh3_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.item       (item),
		.cmd_full   (cmd_full),
		.cmd_push   (f_push),
		.cmd_ctrl   (f_ctrl),
		.cmd_wr_col (f_wr_col),
		.cmd_col_c  (f_col_c),
		.cmd_col_p  (f_col_p),
		.cmd_pixel  (f_pixel)
	);

	sh3_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (sh3_pkg::CMD_DEPTH)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  (cmd_wdata),
		.pop    (b_pop),
		.rdata  (cmd_rdata),
		.empty  (cmd_empty),
		.full   (cmd_full),
		.count  ()
	);

	sh3_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (!cmd_empty),
		.cmd_ctrl   (b_ctrl),
		.cmd_wr_col (b_wr_col),
		.cmd_col_c  (b_col_c),
		.cmd_col_p  (b_col_p),
		.cmd_pixel  (b_pixel),
		.cmd_pop    (b_pop),
		.res_count  (res_count),
		.res_push   (res_push),
		.res_item   (res_item)
	);

	sh3_fifo #(
		.WIDTH (RES_W),
		.DEPTH (sh3_pkg::RES_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wdata),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty),
		.full   (),
		.count  (res_count)
	);

endmodule

/* bench/tb_sharpen_3x3_stream.sv */
// Self-checking testbench for the streaming 3x3 sharpen filter sharpen_3x3_stream.
// Depends on sh3_pkg and the filter RTL; frames of random pixels are streamed through
// the queue ports and every result is checked against a sharpen predictor held here.
`timescale 1ns / 100ps

module tb_sharpen_3x3_stream;

	localparam int MAX_W = 1024;
	localparam int MAX_H = 1024;
	localparam int SETTLE_CYCLES = 24;
	localparam int STALL_LIMIT = 3000;
	localparam int RANDOM_ITEMS = 1020;

	localparam logic [sh3_pkg::PIX_W-1:0] CHECKER [9] = '{
		8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255
	};

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_write = 1'b0;
	logic [1:0]                cfg_index = sh3_pkg::REG_IMAGE_WIDTH;
	logic [sh3_pkg::CFG_W-1:0] cfg_data = '0;
	logic                      push = 1'b0;
	logic                      full;
	sh3_pkg::in_item_t         item = '0;
	logic                      empty;
	logic                      pop = 1'b0;
	sh3_pkg::out_item_t        result;

	sharpen_3x3_stream #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.push     (push),
		.full     (full),
		.item     (item),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sh3_pkg::in_item_t    pending_items [$];
	sh3_pkg::out_item_t   expected_pixels [$];
	sh3_pkg::out_item_t   oldest_pixel;

	logic [sh3_pkg::CFG_W-1:0] reg_width = sh3_pkg::RESET_WIDTH;
	logic [sh3_pkg::CFG_W-1:0] reg_height = sh3_pkg::RESET_HEIGHT;
	logic                      reg_saturate = 1'b0;

	logic [sh3_pkg::PIX_W-1:0] row_store [3][MAX_W];
	int unsigned frame_w = 1, frame_h = 1;
	int unsigned in_col = 0, in_row = 0, out_col = 0, out_row = 0;
	bit          frame_received = 1'b0;

	int unsigned next_fw = 1, next_fh = 1;
	int unsigned stim_count = 0;
	int unsigned requests_taken = 0;
	int unsigned pixels_checked = 0;
	int unsigned frames_seen = 0;
	int unsigned faults = 0;
	int unsigned idle_cycles = 0;

	bit          took = 1'b0;
	int unsigned send_gap = 0;
	bit          send_quiet = 1'b0;
	int unsigned pop_hold = 0;
	bit          pop_quiet = 1'b0;

	function automatic int unsigned clamp_dim(logic [sh3_pkg::CFG_W-1:0] v, int unsigned top);
		if (v == '0)
			return 1;
		return (v > top) ? top : v;
	endfunction

	function automatic int tap(int unsigned r, int unsigned c, bit byp,
		logic [sh3_pkg::PIX_W-1:0] pin);
		if (byp && r == in_row && c == in_col)
			return int'(pin);
		return int'(row_store[r % 3][c]);
	endfunction

	function automatic void emit_sharpened(bit byp, logic [sh3_pkg::PIX_W-1:0] pin);
		int unsigned r, c, rm, rp, cm, cp;
		int acc;
		sh3_pkg::out_item_t res;
		r = out_row;
		c = out_col;
		rm = (r != 0) ? r - 1 : 0;
		rp = (r + 1 < frame_h) ? r + 1 : r;
		cm = (c != 0) ? c - 1 : 0;
		cp = (c + 1 < frame_w) ? c + 1 : c;
		acc = 9 * tap(r, c, byp, pin)
			- tap(rm, cm, byp, pin) - tap(rm, c, byp, pin) - tap(rm, cp, byp, pin)
			- tap(r, cm, byp, pin) - tap(r, cp, byp, pin)
			- tap(rp, cm, byp, pin) - tap(rp, c, byp, pin) - tap(rp, cp, byp, pin);
		if (!reg_saturate)
			res.pixel_out = acc[7:0];
		else if (acc < 0)
			res.pixel_out = 8'd0;
		else if (acc > 255)
			res.pixel_out = 8'd255;
		else
			res.pixel_out = acc[7:0];
		res.end_of_frame = (r + 1 >= frame_h) && (c + 1 >= frame_w);
		expected_pixels.push_back(res);
		if (res.end_of_frame) begin
			in_row = 0;
			in_col = 0;
			out_row = 0;
			out_col = 0;
			frame_received = 1'b0;
		end else if (c + 1 >= frame_w) begin
			out_col = 0;
			out_row = r + 1;
		end else begin
			out_col = c + 1;
		end
	endfunction

	function automatic void predict_sharpen(sh3_pkg::in_item_t req);
		if (req.op == sh3_pkg::OP_PIXEL && !frame_received) begin
			if (in_row == 0 && in_col == 0) begin
				frame_w = clamp_dim(reg_width, MAX_W);
				frame_h = clamp_dim(reg_height, MAX_H);
			end
			if (in_row * frame_w + in_col >= frame_w + 1)
				emit_sharpened(1'b1, req.pixel_in);
			row_store[in_row % 3][in_col] = req.pixel_in;
			if (in_col + 1 >= frame_w) begin
				in_col = 0;
				if (in_row + 1 >= frame_h) begin
					in_row = 0;
					frame_received = 1'b1;
				end else begin
					in_row++;
				end
			end else begin
				in_col++;
			end
		end else if (frame_received) begin
			emit_sharpened(1'b0, '0);
		end
	endfunction

	function automatic int unsigned pick_gap(bit quiet);
		int unsigned r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic logic [sh3_pkg::PIX_W-1:0] rand_pixel();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return 8'd0;
		if (r < 30)
			return 8'd255;
		return sh3_pkg::PIX_W'($urandom_range(0, 255));
	endfunction

	function automatic logic [sh3_pkg::CFG_W-1:0] pick_dim(int unsigned hi);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 6)
			return '0;
		if (r < 88)
			return sh3_pkg::CFG_W'($urandom_range(1, hi));
		return sh3_pkg::CFG_W'($urandom_range(hi + 1, 3 * hi));
	endfunction

	// Register copies follow the port exactly as the block samples it.
	always @(posedge clk) begin
		if (cfg_write) begin
			case (cfg_index)
				sh3_pkg::REG_IMAGE_WIDTH: reg_width = cfg_data;
				sh3_pkg::REG_IMAGE_HEIGHT: reg_height = cfg_data;
				sh3_pkg::REG_SATURATE_MODE: reg_saturate = cfg_data[0];
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		took = arst_n && push && !full;
		if (took) begin
			requests_taken++;
			predict_sharpen(item);
		end
	end

	always @(negedge clk) begin
		if (!push || took) begin
			if (send_gap != 0) begin
				push <= 1'b0;
				send_gap--;
			end else if (pending_items.size() != 0) begin
				item <= pending_items.pop_front();
				push <= 1'b1;
				if ($urandom_range(0, 199) == 0)
					send_quiet = !send_quiet;
				send_gap = pick_gap(send_quiet);
			end else begin
				push <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_pixels.size() == 0) begin
				$error("unexpected result: pixel_out %0d, end_of_frame %0b",
					result.pixel_out, result.end_of_frame);
				faults++;
			end else begin
				oldest_pixel = expected_pixels.pop_front();
				pixels_checked++;
				if (result.pixel_out !== oldest_pixel.pixel_out) begin
					$error("pixel_out: expected %0d, actual %0d",
						oldest_pixel.pixel_out, result.pixel_out);
					faults++;
				end
				if (result.end_of_frame !== oldest_pixel.end_of_frame) begin
					$error("end_of_frame: expected %0b, actual %0b",
						oldest_pixel.end_of_frame, result.end_of_frame);
					faults++;
				end
				if (oldest_pixel.end_of_frame)
					frames_seen++;
			end
		end
	end

	always @(negedge clk) begin
		if ($urandom_range(0, 299) == 0)
			pop_quiet = !pop_quiet;
		if (pop_hold != 0) begin
			pop <= 1'b0;
			pop_hold--;
		end else begin
			pop <= 1'b1;
			if ($urandom_range(0, 9) == 0)
				pop_hold = pick_gap(pop_quiet);
		end
	end

	// The run is abandoned when no request moves on either side for too long.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic add_pixel(logic [sh3_pkg::PIX_W-1:0] v);
		pending_items.push_back(sh3_pkg::in_item_t'{op: sh3_pkg::OP_PIXEL, pixel_in: v});
	endtask

	task automatic add_flush();
		pending_items.push_back(sh3_pkg::in_item_t'{op: sh3_pkg::OP_FLUSH,
			pixel_in: rand_pixel()});
	endtask

	task automatic wait_quiet();
		while (pending_items.size() != 0 || push || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(logic [sh3_pkg::CFG_W-1:0] w, logic [sh3_pkg::CFG_W-1:0] h,
		bit sat);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= sh3_pkg::REG_IMAGE_WIDTH;
		cfg_data <= w;
		@(negedge clk);
		cfg_index <= sh3_pkg::REG_IMAGE_HEIGHT;
		cfg_data <= h;
		@(negedge clk);
		cfg_index <= sh3_pkg::REG_SATURATE_MODE;
		cfg_data <= sh3_pkg::CFG_W'(sat);
		@(negedge clk);
		cfg_write <= 1'b0;
		next_fw = clamp_dim(w, MAX_W);
		next_fh = clamp_dim(h, MAX_H);
	endtask

	task automatic reconfigure_random();
		write_regs(pick_dim(10), pick_dim(6), 1'($urandom_range(0, 1)));
	endtask

	// A frame of random pixels, then exactly the drain it needs. Stray flushes land
	// inside the frame and after it, and some drain requests carry pixels that the
	// block must drop. A split point rewrites the registers part way through.
	task automatic run_frame(int fw, int fh, int split_at);
		int n, drain;
		n = fw * fh;
		for (int i = 0; i < n; i++) begin
			if (i == split_at) begin
				wait_quiet();
				reconfigure_random();
			end
			if ($urandom_range(0, 19) == 0)
				add_flush();
			add_pixel(rand_pixel());
		end
		drain = (n < fw + 1) ? n : fw + 1;
		for (int d = 0; d < drain; d++) begin
			if ($urandom_range(0, 7) == 0)
				add_pixel(rand_pixel());
			else
				add_flush();
		end
		stim_count += n + drain;
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) add_flush();
	endtask

	initial begin
		int fw, fh, split;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_regs('0, '0, 1'b0);
		add_pixel(8'd255);
		add_flush();
		add_flush();
		wait_quiet();
		write_regs(11'd3, 11'd3, 1'b0);
		for (int i = 0; i < 9; i++) begin
			if (i == 4)
				add_flush();
			add_pixel(CHECKER[i]);
		end
		add_flush();
		add_flush();
		add_pixel(8'd77);
		add_flush();
		wait_quiet();
		write_regs(11'd3, 11'd3, 1'b1);
		for (int i = 0; i < 9; i++)
			add_pixel(CHECKER[i]);
		repeat (4) add_flush();

		while (stim_count < RANDOM_ITEMS) begin
			if ($urandom_range(0, 1) == 1) begin
				wait_quiet();
				reconfigure_random();
			end
			fw = next_fw;
			fh = next_fh;
			split = -1;
			if (fw * fh > 1 && $urandom_range(0, 4) == 0)
				split = $urandom_range(1, fw * fh - 1);
			run_frame(fw, fh, split);
		end
		wait_quiet();

		$display("Streamed %0d requests in %0d frames; %0d sharpened pixels compared.",
			requests_taken, frames_seen, pixels_checked);
		$display("Frame sizes were drawn at random, zero sizes included, wrapped and saturated.");
		if (faults == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
